// File: hw/rtl/uracc_pkg.sv
package uracc_pkg;

   localparam int UID_W = 32;
   localparam int ROLE_W = 8;

   localparam logic [1:0] REQ_SET = 2'd0;
   localparam logic [1:0] REQ_ACCESS = 2'd1;
   localparam logic [1:0] REQ_CRTDEL = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NEW = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [ROLE_W-1:0] MY_READ = 8'd1;
   localparam logic [ROLE_W-1:0] ROLE_CREATE_DELETE = 8'd3;
   localparam logic WRITE_PERM = 1'b1;

   // Search token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic              valid;
      logic [1:0]        req_type;
      logic [UID_W-1:0]  user_id;
      logic [ROLE_W-1:0] role;
      logic              want_write;
      logic              found;
      logic [ROLE_W-1:0] held;
      logic              free_seen;
   } token_type;

   // Table update broadcast to every cell once the token has left the row.
   typedef struct packed {
      logic              en;
      logic              to_hit;
      logic [UID_W-1:0]  user_id;
      logic [ROLE_W-1:0] role;
   } write_type;

endpackage

// File: hw/rtl/uracc_cell.sv
module uracc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  uracc_pkg::token_type  tok_in,
   output uracc_pkg::token_type  tok_out,
   input  uracc_pkg::write_type  wr
);

   logic                         valid_ff;
   logic [uracc_pkg::UID_W-1:0]  user_ff;
   logic [uracc_pkg::ROLE_W-1:0] role_ff;
   logic                         hit_mark_ff;
   logic                         free_mark_ff;
   uracc_pkg::token_type         tok_ff;
   uracc_pkg::token_type         tok_in_next;
   logic                         match;

   assign match = valid_ff && (user_ff == tok_in.user_id);

   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         if (!tok_in.found && match) begin
            tok_in_next.found = 1'b1;
            tok_in_next.held = role_ff;
         end
         if (!tok_in.free_seen && !valid_ff) begin
            tok_in_next.free_seen = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
         if (wr.en && !wr.to_hit && free_mark_ff) begin
            valid_ff <= 1'b1;
         end
      end
   end

   // The marks remember whether this cell is the hit or the first free entry.
   always_ff @(posedge clock) begin
      if (tok_in.valid) begin
         hit_mark_ff <= !tok_in.found && match;
         free_mark_ff <= !tok_in.free_seen && !valid_ff;
      end
      if (wr.en && wr.to_hit && hit_mark_ff) begin
         role_ff <= wr.role;
      end
      if (wr.en && !wr.to_hit && free_mark_ff) begin
         user_ff <= wr.user_id;
         role_ff <= wr.role;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: hw/rtl/uid_role_access_checker_top.sv
// User id to role table with access checks.
// The req_ channel carries one item: a set of a role for a user id, an access
// check or a create or delete check. The rsp_ channel returns one item per
// request with allowed, user_found and status.
// Each entry lives in one cell of a row; a search token moves one cell per
// cycle through the row. As it leaves the row the table is updated and the
// result is formed in the result slot and then moves to the rsp_ register.
// One item is in flight at a time: a new item is accepted only after the
// result of the last one has left the result slot.
// A finished result may wait in the rsp_ register while the next item is
// accepted and searched; a stalled receiver holds the output steady and the
// row waits for the result slot before the next item is taken.
// Synchronous reset clears all entries and empties both channels.
module uid_role_access_checker_top #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_user_id,
   input  logic [7:0]  req_role,
   input  logic        req_want_write,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_allowed,
   output logic        rsp_user_found,
   output logic [1:0]  rsp_status
);

   uracc_pkg::token_type tok [TABLE_ENTRIES+1];
   uracc_pkg::write_type wr;
   uracc_pkg::token_type tok_end;

   logic       busy_ff;
   logic       res_pend_ff;
   logic       res_allowed_ff;
   logic       res_found_ff;
   logic [1:0] res_status_ff;
   logic       rsp_valid_ff;
   logic       rsp_allowed_ff;
   logic       rsp_found_ff;
   logic [1:0] rsp_status_ff;
   logic       allowed_in;
   logic [1:0] status_in;
   logic       accept;
   logic       move;

   assign req_stall = busy_ff;
   assign accept = req_valid && !busy_ff;

   always_comb begin
      tok[0].valid = accept;
      tok[0].req_type = req_type;
      tok[0].user_id = req_user_id;
      tok[0].role = req_role;
      tok[0].want_write = req_want_write;
      tok[0].found = 1'b0;
      tok[0].held = '0;
      tok[0].free_seen = 1'b0;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      uracc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1]),
         .wr      (wr)
      );
   end

   assign tok_end = tok[TABLE_ENTRIES];

   always_comb begin
      allowed_in = 1'b0;
      status_in = uracc_pkg::ST_OK;
      wr.en = 1'b0;
      wr.to_hit = tok_end.found;
      wr.user_id = tok_end.user_id;
      wr.role = tok_end.role;
      case (tok_end.req_type)
         uracc_pkg::REQ_SET: begin
            if (tok_end.found) begin
               wr.en = tok_end.valid;
               status_in = uracc_pkg::ST_OK;
            end else if (tok_end.free_seen) begin
               wr.en = tok_end.valid;
               status_in = uracc_pkg::ST_NEW;
            end else begin
               status_in = uracc_pkg::ST_FULL;
            end
         end
         uracc_pkg::REQ_ACCESS: begin
            if (tok_end.user_id == '0) begin
               allowed_in = 1'b1;
            end else if (!tok_end.found) begin
               allowed_in = 1'b0;
            end else if (tok_end.held == uracc_pkg::MY_READ &&
                         (tok_end.want_write & uracc_pkg::WRITE_PERM)) begin
               allowed_in = 1'b0;
            end else begin
               allowed_in = 1'b1;
            end
         end
         uracc_pkg::REQ_CRTDEL: begin
            allowed_in = (tok_end.user_id == '0) ||
                         (tok_end.found &&
                          tok_end.held == uracc_pkg::ROLE_CREATE_DELETE);
         end
         default: begin
            allowed_in = 1'b0;
         end
      endcase
   end

   assign move = res_pend_ff && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         res_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (move) begin
            busy_ff <= 1'b0;
         end
         if (tok_end.valid) begin
            res_pend_ff <= 1'b1;
         end else if (move) begin
            res_pend_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tok_end.valid) begin
         res_allowed_ff <= allowed_in;
         res_found_ff <= tok_end.found;
         res_status_ff <= status_in;
      end
      if (move) begin
         rsp_allowed_ff <= res_allowed_ff;
         rsp_found_ff <= res_found_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_allowed = rsp_allowed_ff;
   assign rsp_user_found = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

endmodule
